// ===== rtl/core/vafp_pkg.sv =====
// Shared types, constants and elaboration-time functions for the vertex angle pipeline.
package vafp_pkg;

   localparam int XW           = 64;  // arm vector component width inside the datapath
   localparam int ZW           = 40;  // angle accumulator width, degrees Q28
   localparam int ZFRAC        = 28;
   localparam int CORDIC_STEPS = 40;
   localparam int NORM_TOP     = 60;  // normalized magnitude lands in [2^59, 2^60)
   localparam int NORM_STAGES  = 6;   // shifts of 32, 16, 8, 4, 2, 1

   localparam logic [63:0] DEG_PER_RAD_Q56 = 64'd4128596020240314161;

   typedef logic signed [XW-1:0] xy_type;
   typedef logic signed [ZW-1:0] zang_type;

   localparam zang_type HALF_TURN = zang_type'(180) <<< ZFRAC;

   typedef struct packed {
      xy_type   x;
      xy_type   y;
      zang_type z;
   } lane_type;

   typedef struct packed {
      lane_type u;
      lane_type w;
      logic     degen;
   } pipe_type;

   // shift-subtract divide, used only on constants
   function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
      logic [63:0] q;
      logic [64:0] r;
      q = '0;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         r = {r[63:0], n[b]};
         if (r >= {1'b0, d}) begin
            r    = r - {1'b0, d};
            q[b] = 1'b1;
         end
      end
      return q;
   endfunction

   // atan(2^-i) in degrees, Q28, from the arctangent series
   function automatic zang_type step_angle(input int i);
      logic signed [63:0] sum;
      logic [63:0]        t;
      int                 k;
      sum = '0;
      if (i == 0) begin
         return zang_type'(45) <<< ZFRAC;
      end
      for (k = 0; i * (2 * k + 1) <= 63; k++) begin
         t = udiv64(DEG_PER_RAD_Q56 >> (i * (2 * k + 1)), 64'(2 * k + 1));
         if (k[0]) begin
            sum = sum - signed'(t);
         end else begin
            sum = sum + signed'(t);
         end
      end
      return zang_type'((sum + (64'sd1 <<< 27)) >>> 28);
   endfunction

endpackage

// ===== rtl/core/vafp_norm_stage.sv =====
// One step of the left-shift normalizer applied to both arm vectors.
module vafp_norm_stage
   import vafp_pkg::*;
#(
   parameter int SHIFT = 32
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     en,
   input  logic     valid_in,
   input  pipe_type stage_data,
   output logic     valid_ff,
   output pipe_type data_ff
);

   pipe_type data_in;

   function automatic lane_type norm(input lane_type a);
      xy_type   ax;
      xy_type   ay;
      lane_type r;
      ax = a.x[XW-1] ? -a.x : a.x;
      ay = a.y[XW-1] ? -a.y : a.y;
      r  = a;
      if (((ax | ay) >> (NORM_TOP - SHIFT)) == '0) begin
         r.x = a.x <<< SHIFT;
         r.y = a.y <<< SHIFT;
      end
      return r;
   endfunction

   always_comb begin
      data_in       = stage_data;
      data_in.u     = norm(stage_data.u);
      data_in.w     = norm(stage_data.w);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
      end
   end

endmodule

// ===== rtl/core/vafp_turn_stage.sv =====
// Half-turn pre-rotation: left half-plane vectors are mirrored and start at 180 degrees.
module vafp_turn_stage
   import vafp_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     en,
   input  logic     valid_in,
   input  pipe_type stage_data,
   output logic     valid_ff,
   output pipe_type data_ff
);

   pipe_type data_in;

   function automatic lane_type turn(input lane_type a);
      lane_type r;
      r = a;
      if (a.x[XW-1]) begin
         r.x = -a.x;
         r.y = -a.y;
         r.z = HALF_TURN;
      end else begin
         r.z = '0;
      end
      return r;
   endfunction

   always_comb begin
      data_in   = stage_data;
      data_in.u = turn(stage_data.u);
      data_in.w = turn(stage_data.w);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
      end
   end

endmodule

// ===== rtl/core/vafp_cordic_stage.sv =====
// One vectoring CORDIC iteration on both arm vectors.
module vafp_cordic_stage
   import vafp_pkg::*;
#(
   parameter int STEP = 0
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     en,
   input  logic     valid_in,
   input  pipe_type stage_data,
   output logic     valid_ff,
   output pipe_type data_ff
);

   localparam zang_type STEP_ANGLE = step_angle(STEP);

   pipe_type data_in;

   function automatic lane_type rot(input lane_type a);
      xy_type   dx;
      xy_type   dy;
      lane_type r;
      dx = a.y >>> STEP;  // arithmetic shift floors
      dy = a.x >>> STEP;
      if (!a.y[XW-1]) begin
         r.x = a.x + dx;
         r.y = a.y - dy;
         r.z = a.z + STEP_ANGLE;
      end else begin
         r.x = a.x - dx;
         r.y = a.y + dy;
         r.z = a.z - STEP_ANGLE;
      end
      return r;
   endfunction

   always_comb begin
      data_in   = stage_data;
      data_in.u = rot(stage_data.u);
      data_in.w = rot(stage_data.w);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
      end
   end

endmodule

// ===== rtl/core/vafp_angle_out.sv =====
// Angle difference folding, rounding and the response register.
module vafp_angle_out
   import vafp_pkg::*;
#(
   parameter int ANGLE_FRAC_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         valid_in,
   input  pipe_type                     data_in,
   output logic                         rsp_valid,
   output logic [ANGLE_FRAC_BITS+7:0]   rsp_angle_deg,
   output logic                         rsp_degenerate
);

   localparam int       OUT_W = ANGLE_FRAC_BITS + 8;
   localparam int       SH    = ZFRAC - ANGLE_FRAC_BITS;
   localparam zang_type RND   = zang_type'(1) <<< (SH - 1);
   localparam zang_type TOP   = zang_type'(180) <<< ANGLE_FRAC_BITS;

   logic     fold_valid_ff;
   zang_type fold_ff;
   zang_type fold_in;
   logic     fold_degen_ff;
   zang_type diff;
   zang_type mag;
   zang_type rnd;
   zang_type lim;

   always_comb begin
      diff = data_in.u.z - data_in.w.z;
      mag  = diff[ZW-1] ? -diff : diff;
      if (mag > HALF_TURN) begin
         mag = (HALF_TURN <<< 1) - mag;
      end
      fold_in = mag;
      if (mag[ZW-1]) begin
         fold_in = '0;
      end else if (mag > HALF_TURN) begin
         fold_in = HALF_TURN;
      end
   end

   always_comb begin
      rnd = (fold_ff + RND) >>> SH;
      lim = (rnd > TOP) ? TOP : rnd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fold_valid_ff <= 1'b0;
         rsp_valid     <= 1'b0;
      end else if (en) begin
         fold_valid_ff <= valid_in;
         rsp_valid     <= fold_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         fold_ff        <= fold_in;
         fold_degen_ff  <= data_in.degen;
         rsp_degenerate <= fold_degen_ff;
         rsp_angle_deg  <= fold_degen_ff ? '0 : lim[OUT_W-1:0];
      end
   end

endmodule

// ===== rtl/core/vertex_angle_from_three_points_unit.sv =====
// Top level of the vertex angle unit: input stage and pipeline assembly.
// Takes one point triple per clock, unless a stall on rsp_ready holds it, and
// returns the angle at the vertex, in degrees, through 50 register stages.
// Both arm vectors are normalized by left shifts (6 stages), mirrored into
// the right half plane (1 stage), and run side by side through a 40-stage
// vectoring CORDIC; an input stage before and two folding/rounding stages
// after make up the rest.
// The whole pipeline advances together: while a result waits on rsp_ready,
// every stage holds and req_ready is low.
module vertex_angle_from_three_points_unit
   import vafp_pkg::*;
#(
   parameter int COORD_WIDTH     = 32,
   parameter int ANGLE_FRAC_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [COORD_WIDTH-1:0]     req_vertex_x,
   input  logic signed [COORD_WIDTH-1:0]     req_vertex_y,
   input  logic signed [COORD_WIDTH-1:0]     req_first_x,
   input  logic signed [COORD_WIDTH-1:0]     req_first_y,
   input  logic signed [COORD_WIDTH-1:0]     req_second_x,
   input  logic signed [COORD_WIDTH-1:0]     req_second_y,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [ANGLE_FRAC_BITS+7:0]        rsp_angle_deg,
   output logic                              rsp_degenerate
);

   localparam int NSTG = NORM_STAGES + 1 + CORDIC_STEPS;

   logic     en;
   logic     in_valid_ff;
   pipe_type in_ff;
   pipe_type in_in;
   xy_type   ux, uy, wx, wy;

   logic     stg_valid [NSTG+1];
   pipe_type stg_data  [NSTG+1];

   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   always_comb begin
      ux = xy_type'(req_first_x)  - xy_type'(req_vertex_x);
      uy = xy_type'(req_first_y)  - xy_type'(req_vertex_y);
      wx = xy_type'(req_second_x) - xy_type'(req_vertex_x);
      wy = xy_type'(req_second_y) - xy_type'(req_vertex_y);
      in_in.u.x  = ux;
      in_in.u.y  = uy;
      in_in.u.z  = '0;
      in_in.w.x  = wx;
      in_in.w.y  = wy;
      in_in.w.z  = '0;
      in_in.degen = ((ux == '0) && (uy == '0)) || ((wx == '0) && (wy == '0));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (en) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         in_ff <= in_in;
      end
   end

   assign stg_valid[0] = in_valid_ff;
   assign stg_data[0]  = in_ff;

   for (genvar j = 0; j < NORM_STAGES; j++) begin : g_norm
      vafp_norm_stage #(.SHIFT(32 >> j)) u_norm (
         .clock      (clock),
         .reset      (reset),
         .en         (en),
         .valid_in   (stg_valid[j]),
         .stage_data (stg_data[j]),
         .valid_ff   (stg_valid[j+1]),
         .data_ff    (stg_data[j+1])
      );
   end

   vafp_turn_stage u_turn (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .valid_in   (stg_valid[NORM_STAGES]),
      .stage_data (stg_data[NORM_STAGES]),
      .valid_ff   (stg_valid[NORM_STAGES+1]),
      .data_ff    (stg_data[NORM_STAGES+1])
   );

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
      vafp_cordic_stage #(.STEP(i)) u_step (
         .clock      (clock),
         .reset      (reset),
         .en         (en),
         .valid_in   (stg_valid[NORM_STAGES+1+i]),
         .stage_data (stg_data[NORM_STAGES+1+i]),
         .valid_ff   (stg_valid[NORM_STAGES+2+i]),
         .data_ff    (stg_data[NORM_STAGES+2+i])
      );
   end

   vafp_angle_out #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_out (
      .clock          (clock),
      .reset          (reset),
      .en             (en),
      .valid_in       (stg_valid[NSTG]),
      .data_in        (stg_data[NSTG]),
      .rsp_valid      (rsp_valid),
      .rsp_angle_deg  (rsp_angle_deg),
      .rsp_degenerate (rsp_degenerate)
   );

endmodule
